>>> rtl/dts_pkg.sv
// shared types, constants and helpers for the dfa token scanner
package dts_pkg;

  localparam int NumStates = 256;
  localparam int TagBits = 16;
  localparam int LenBits = 16;

  // field widths of the item formats
  localparam int FuncBits = 2;
  localparam int StateBits = 8;
  localparam int SymBits = 8;
  localparam int NextBits = 9;
  localparam int TagWidth = 16;
  localparam int LenWidth = 16;

  localparam int TransAddrBits = StateBits + SymBits;
  localparam int TransDepth = 2 ** TransAddrBits;
  localparam int AttrBits = 1 + TagWidth;
  localparam int AttrDepth = 2 ** StateBits;

  localparam int QueueDepth = 4;
  localparam int QueuePtrBits = $clog2(QueueDepth);
  localparam int QueueCntBits = $clog2(QueueDepth + 1);

  localparam logic [TagWidth-1:0] TagMask = TagWidth'((64'd1 << TagBits) - 64'd1);
  localparam logic [LenWidth-1:0] LenMax = LenWidth'((64'd1 << LenBits) - 64'd1);

  localparam logic [FuncBits-1:0] FuncWrTrans = 2'd0;
  localparam logic [FuncBits-1:0] FuncWrAttr = 2'd1;
  localparam logic [FuncBits-1:0] FuncScan = 2'd2;

  localparam logic KindToken = 1'b0;
  localparam logic KindDrop = 1'b1;

  typedef enum logic [1:0] {
    OpWrTrans,
    OpWrAttr,
    OpScan
  } op_e;

  typedef struct packed {
    logic [FuncBits-1:0]  func;
    logic [StateBits-1:0] state_sel;
    logic [SymBits-1:0]   symbol;
    logic [NextBits-1:0]  next_state;
    logic                 accept_in;
    logic [TagWidth-1:0]  tag_in;
    logic                 end_of_input;
  } in_item_t;

  typedef struct packed {
    logic                kind;
    logic [TagWidth-1:0] token_tag;
    logic [LenWidth-1:0] token_length;
    logic                matched;
    logic                last;
  } out_item_t;

  typedef struct packed {
    op_e                  op;
    logic [StateBits-1:0] sel;
    logic [SymBits-1:0]   sym;
    logic [NextBits-1:0]  nxt;
    logic                 acc;
    logic [TagWidth-1:0]  tag;
    logic                 eoi;
  } queue_entry_t;

  typedef struct packed {
    logic         valid;
    queue_entry_t entry;
  } queue_head_t;

  typedef struct packed {
    logic                     we;
    logic [TransAddrBits-1:0] waddr;
    logic [NextBits-1:0]      wdata;
    logic                     re;
    logic [TransAddrBits-1:0] raddr;
  } trans_req_t;

  typedef struct packed {
    logic                 we;
    logic [StateBits-1:0] waddr;
    logic [AttrBits-1:0]  wdata;
    logic                 re;
    logic [StateBits-1:0] raddr;
  } attr_req_t;

  function automatic logic state_oob(logic [StateBits-1:0] s);
    return {24'd0, s} >= 32'(NumStates);
  endfunction

  function automatic logic target_oob(logic [NextBits-1:0] n);
    return n[NextBits-1] || ({23'd0, n} >= 32'(NumStates));
  endfunction

endpackage

>>> rtl/dfa_token_scanner_top.sv
// top level of the table driven dfa token scanner
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i / in_stall_o   dts_pkg::in_item_t
//   out      output     out_valid_o / out_stall_i dts_pkg::out_item_t
//   cfg      input      cfg_we_i                  cfg_wdata_i (initial state)
//
// a table write is issued from the idle state; a scanned byte reads the transition ram,
// then the accept/tag ram, after an idle issue step when it does not follow a scan directly;
// a token that ends on a missing edge or by leaving the accepting states is closed and the
// byte is retried from the initial state, and end of input closes the last token in StEoi.
// each result waits in its state until the single output register is free of out_stall_i;
// reset leaves the tables undefined and a four entry queue keeps the input side accepting.
module dfa_token_scanner_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  dts_pkg::in_item_t             in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output dts_pkg::out_item_t            out_item_o,
  input  logic                          cfg_we_i,
  input  logic [dts_pkg::StateBits-1:0] cfg_wdata_i
);

  logic [dts_pkg::StateBits-1:0] init_q;
  dts_pkg::queue_head_t head;
  logic pop;
  dts_pkg::trans_req_t trans_req;
  dts_pkg::attr_req_t attr_req;
  logic [dts_pkg::NextBits-1:0] trans_rdata;
  logic [dts_pkg::AttrBits-1:0] attr_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q <= '0;
    end else if (cfg_we_i) begin
      init_q <= cfg_wdata_i;
    end
  end

  dts_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .head_o     (head),
    .pop_i      (pop)
  );

  dts_ram #(
    .Width (dts_pkg::NextBits),
    .Depth (dts_pkg::TransDepth)
  ) u_trans_ram (
    .clk_i   (clk_i),
    .we_i    (trans_req.we),
    .waddr_i (trans_req.waddr),
    .wdata_i (trans_req.wdata),
    .re_i    (trans_req.re),
    .raddr_i (trans_req.raddr),
    .rdata_o (trans_rdata)
  );

  dts_ram #(
    .Width (dts_pkg::AttrBits),
    .Depth (dts_pkg::AttrDepth)
  ) u_attr_ram (
    .clk_i   (clk_i),
    .we_i    (attr_req.we),
    .waddr_i (attr_req.waddr),
    .wdata_i (attr_req.wdata),
    .re_i    (attr_req.re),
    .raddr_i (attr_req.raddr),
    .rdata_o (attr_rdata)
  );

  dts_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .init_i        (init_q),
    .head_i        (head),
    .pop_o         (pop),
    .trans_req_o   (trans_req),
    .trans_rdata_i (trans_rdata),
    .attr_req_o    (attr_req),
    .attr_rdata_i  (attr_rdata),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_item_o    (out_item_o)
  );

endmodule

>>> rtl/dts_ram.sv
// generic single write port, single read port ram with registered read
module dts_ram #(
  parameter int Width = 8,
  parameter int Depth = 256,
  localparam int AddrBits = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrBits-1:0] waddr_i,
  input  logic [Width-1:0]    wdata_i,
  input  logic                re_i,
  input  logic [AddrBits-1:0] raddr_i,
  output logic [Width-1:0]    rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/dts_front.sv
// front end: accepts items, decodes them and queues the useful ones
module dts_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  dts_pkg::in_item_t     in_item_i,
  output dts_pkg::queue_head_t  head_o,
  input  logic                  pop_i
);

  dts_pkg::queue_entry_t entries_q [dts_pkg::QueueDepth];
  logic [dts_pkg::QueuePtrBits-1:0] wr_ptr_q, wr_ptr_d;
  logic [dts_pkg::QueuePtrBits-1:0] rd_ptr_q, rd_ptr_d;
  logic [dts_pkg::QueueCntBits-1:0] count_q, count_d;

  dts_pkg::queue_entry_t entry;
  logic keep;
  logic push;
  logic pop;

  // unused func code and loads to missing states are swallowed here
  always_comb begin
    entry.op = dts_pkg::OpScan;
    entry.sel = in_item_i.state_sel;
    entry.sym = in_item_i.symbol;
    entry.nxt = in_item_i.next_state;
    entry.acc = in_item_i.accept_in;
    entry.tag = in_item_i.tag_in & dts_pkg::TagMask;
    entry.eoi = in_item_i.end_of_input;
    keep = 1'b0;
    case (in_item_i.func)
      dts_pkg::FuncWrTrans: begin
        entry.op = dts_pkg::OpWrTrans;
        keep = !dts_pkg::state_oob(in_item_i.state_sel);
      end
      dts_pkg::FuncWrAttr: begin
        entry.op = dts_pkg::OpWrAttr;
        keep = !dts_pkg::state_oob(in_item_i.state_sel);
      end
      dts_pkg::FuncScan: begin
        entry.op = dts_pkg::OpScan;
        keep = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_stall_o = (count_q == dts_pkg::QueueCntBits'(dts_pkg::QueueDepth));
  assign push = in_valid_i && !in_stall_o && keep;
  assign pop = pop_i && (count_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == dts_pkg::QueuePtrBits'(dts_pkg::QueueDepth - 1)) ?
                 '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == dts_pkg::QueuePtrBits'(dts_pkg::QueueDepth - 1)) ?
                 '0 : rd_ptr_q + 1'b1;
    end
    case ({push, pop})
      2'b10: count_d = count_q + 1'b1;
      2'b01: count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= entry;
    end
  end

  assign head_o.valid = (count_q != '0);
  assign head_o.entry = entries_q[rd_ptr_q];

endmodule

>>> rtl/dts_back.sv
// back end: table writes, dfa stepping, token bookkeeping and result register
module dts_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [dts_pkg::StateBits-1:0]  init_i,
  input  dts_pkg::queue_head_t           head_i,
  output logic                           pop_o,
  output dts_pkg::trans_req_t            trans_req_o,
  input  logic [dts_pkg::NextBits-1:0]   trans_rdata_i,
  output dts_pkg::attr_req_t             attr_req_o,
  input  logic [dts_pkg::AttrBits-1:0]   attr_rdata_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output dts_pkg::out_item_t             out_item_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StTrd = 2'd1;
  localparam logic [1:0] StArd = 2'd2;
  localparam logic [1:0] StEoi = 2'd3;

  logic [1:0] state_q, state_d;
  logic [dts_pkg::StateBits-1:0] cur_q, cur_d;
  logic [dts_pkg::LenWidth-1:0] cnt_q, cnt_d;
  logic seen_q, seen_d;
  logic [dts_pkg::TagWidth-1:0] best_q, best_d;
  logic retry_q, retry_d;
  logic [dts_pkg::StateBits-1:0] nx_q, nx_d;
  logic [dts_pkg::SymBits-1:0] sym_q, sym_d;
  logic eoi_q, eoi_d;
  logic src_oob_q, src_oob_d;
  logic out_valid_q, out_valid_d;
  dts_pkg::out_item_t out_q, out_d;

  logic [dts_pkg::StateBits-1:0] lookup_state;
  logic head_scan;
  logic out_free;
  logic miss;
  logic fail;
  logic emit;
  dts_pkg::out_item_t emit_item;
  logic acc;
  logic [dts_pkg::TagWidth-1:0] tag;

  // an empty token always starts from the configured initial state
  assign lookup_state = (cnt_q == '0) ? init_i : cur_q;
  assign head_scan = head_i.valid && (head_i.entry.op == dts_pkg::OpScan);
  assign out_free = !out_valid_q || !out_stall_i;
  assign miss = src_oob_q || dts_pkg::target_oob(trans_rdata_i);
  assign acc = attr_rdata_i[dts_pkg::AttrBits-1];
  assign tag = attr_rdata_i[dts_pkg::TagWidth-1:0];

  always_comb begin
    state_d = state_q;
    cur_d = cur_q;
    cnt_d = cnt_q;
    seen_d = seen_q;
    best_d = best_q;
    retry_d = retry_q;
    nx_d = nx_q;
    sym_d = sym_q;
    eoi_d = eoi_q;
    src_oob_d = src_oob_q;
    pop_o = 1'b0;
    trans_req_o = '0;
    attr_req_o = '0;
    fail = 1'b0;
    emit = 1'b0;
    emit_item = '0;

    case (state_q)
      StIdle: begin
        if (head_i.valid) begin
          pop_o = 1'b1;
          case (head_i.entry.op)
            dts_pkg::OpWrTrans: begin
              trans_req_o.we = 1'b1;
              trans_req_o.waddr = {head_i.entry.sel, head_i.entry.sym};
              trans_req_o.wdata = head_i.entry.nxt;
            end
            dts_pkg::OpWrAttr: begin
              attr_req_o.we = 1'b1;
              attr_req_o.waddr = head_i.entry.sel;
              attr_req_o.wdata = {head_i.entry.acc, head_i.entry.tag};
            end
            dts_pkg::OpScan: begin
              sym_d = head_i.entry.sym;
              eoi_d = head_i.entry.eoi;
              src_oob_d = dts_pkg::state_oob(lookup_state);
              trans_req_o.re = 1'b1;
              trans_req_o.raddr = {lookup_state, head_i.entry.sym};
              state_d = StTrd;
            end
            default: begin
              pop_o = 1'b1;
            end
          endcase
        end
      end
      StTrd: begin
        if (retry_q) begin
          // the closed token goes out once the retry shows whether more results follow
          if (out_free) begin
            emit = 1'b1;
            emit_item.kind = dts_pkg::KindToken;
            emit_item.token_tag = best_q;
            emit_item.token_length = cnt_q;
            emit_item.matched = seen_q;
            emit_item.last = !miss && !eoi_q;
            cnt_d = '0;
            seen_d = 1'b0;
            best_d = '0;
            retry_d = 1'b0;
            if (!miss) begin
              nx_d = trans_rdata_i[dts_pkg::StateBits-1:0];
              attr_req_o.re = 1'b1;
              attr_req_o.raddr = trans_rdata_i[dts_pkg::StateBits-1:0];
              state_d = StArd;
            end
          end
        end else if (miss) begin
          fail = 1'b1;
        end else begin
          nx_d = trans_rdata_i[dts_pkg::StateBits-1:0];
          attr_req_o.re = 1'b1;
          attr_req_o.raddr = trans_rdata_i[dts_pkg::StateBits-1:0];
          state_d = StArd;
        end
      end
      StArd: begin
        // leaving the accepting region ends the token
        if (!acc && seen_q) begin
          fail = 1'b1;
        end else begin
          cur_d = nx_q;
          cnt_d = (cnt_q == dts_pkg::LenMax) ? cnt_q : cnt_q + 1'b1;
          if (acc) begin
            seen_d = 1'b1;
            best_d = tag;
          end
          if (eoi_q) begin
            state_d = StEoi;
          end else if (head_scan) begin
            // chain the next byte straight from the new state
            pop_o = 1'b1;
            sym_d = head_i.entry.sym;
            eoi_d = head_i.entry.eoi;
            src_oob_d = dts_pkg::state_oob(nx_q);
            trans_req_o.re = 1'b1;
            trans_req_o.raddr = {nx_q, head_i.entry.sym};
            state_d = StTrd;
          end else begin
            state_d = StIdle;
          end
        end
      end
      StEoi: begin
        if (out_free) begin
          emit = 1'b1;
          emit_item.kind = dts_pkg::KindToken;
          emit_item.token_tag = best_q;
          emit_item.token_length = cnt_q;
          emit_item.matched = seen_q;
          emit_item.last = 1'b1;
          cnt_d = '0;
          seen_d = 1'b0;
          best_d = '0;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    // a failed step closes the open token and retries the byte, or drops it
    if (fail) begin
      if (cnt_q != '0) begin
        retry_d = 1'b1;
        src_oob_d = dts_pkg::state_oob(init_i);
        trans_req_o.re = 1'b1;
        trans_req_o.raddr = {init_i, sym_q};
        state_d = StTrd;
      end else if (out_free) begin
        emit = 1'b1;
        emit_item.kind = dts_pkg::KindDrop;
        emit_item.last = !eoi_q;
        state_d = eoi_q ? StEoi : StIdle;
      end
    end
  end

  always_comb begin
    out_d = out_q;
    out_valid_d = out_valid_q;
    if (emit) begin
      out_d = emit_item;
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cur_q <= '0;
      cnt_q <= '0;
      seen_q <= 1'b0;
      best_q <= '0;
      retry_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cur_q <= cur_d;
      cnt_q <= cnt_d;
      seen_q <= seen_d;
      best_q <= best_d;
      retry_q <= retry_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nx_q <= nx_d;
    sym_q <= sym_d;
    eoi_q <= eoi_d;
    src_oob_q <= src_oob_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o = out_q;

endmodule

>>> verif/dfa_token_scanner_checker.sv
`timescale 1ns / 1ps
// checker: predicts the dfa token scanner results and compares them with the output channel
module dfa_token_scanner_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  dts_pkg::in_item_t             in_item_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  dts_pkg::out_item_t            out_item_i,
  input  logic                          cfg_we_i,
  input  logic [dts_pkg::StateBits-1:0] cfg_wdata_i,
  output int                            pending_o,
  output int                            fail_count_o
);

  typedef enum logic [1:0] {
    WalkOk,
    WalkNoEdge,
    WalkEnded
  } walk_e;

  logic [dts_pkg::NextBits-1:0]  trans_mem [dts_pkg::TransDepth];
  logic                          accept_mem [dts_pkg::NumStates];
  logic [dts_pkg::TagWidth-1:0]  tag_mem [dts_pkg::NumStates];
  logic [dts_pkg::StateBits-1:0] start_state;
  logic [dts_pkg::StateBits-1:0] cur_state;
  logic [dts_pkg::LenWidth-1:0]  tok_len;
  logic                          tok_seen_acc;
  logic [dts_pkg::TagWidth-1:0]  tok_tag;
  dts_pkg::out_item_t            token_results_q [$];
  dts_pkg::out_item_t            burst [3];
  dts_pkg::out_item_t            want;
  int                            n_burst;
  int                            fails = 0;

  assign pending_o = token_results_q.size();
  assign fail_count_o = fails;

  function automatic void restart_token();
    cur_state = start_state;
    tok_len = '0;
    tok_seen_acc = 1'b0;
    tok_tag = '0;
  endfunction

  // one dfa step on the current token
  function automatic walk_e walk_edge(logic [dts_pkg::SymBits-1:0] sym);
    logic [dts_pkg::NextBits-1:0] nx;
    nx = trans_mem[{cur_state, sym}];
    if (int'(cur_state) >= dts_pkg::NumStates || int'(nx) >= dts_pkg::NumStates) begin
      return WalkNoEdge;
    end
    if (!accept_mem[nx[dts_pkg::StateBits-1:0]] && tok_seen_acc) return WalkEnded;
    cur_state = nx[dts_pkg::StateBits-1:0];
    if (tok_len != dts_pkg::LenMax) tok_len++;
    if (accept_mem[cur_state]) begin
      tok_seen_acc = 1'b1;
      tok_tag = tag_mem[cur_state];
    end
    return WalkOk;
  endfunction

  function automatic void add_result(logic k, logic [dts_pkg::TagWidth-1:0] tg,
                                     logic [dts_pkg::LenWidth-1:0] ln, logic mt);
    burst[n_burst] = '{kind: k, token_tag: tg, token_length: ln, matched: mt, last: 1'b0};
    n_burst++;
  endfunction

  function automatic void lex_item(dts_pkg::in_item_t it);
    int i;
    n_burst = 0;
    case (it.func)
      dts_pkg::FuncWrTrans: begin
        if (int'(it.state_sel) < dts_pkg::NumStates) begin
          trans_mem[{it.state_sel, it.symbol}] = it.next_state;
        end
      end
      dts_pkg::FuncWrAttr: begin
        if (int'(it.state_sel) < dts_pkg::NumStates) begin
          accept_mem[it.state_sel] = it.accept_in;
          tag_mem[it.state_sel] = it.tag_in & dts_pkg::TagMask;
        end
      end
      dts_pkg::FuncScan: begin
        if (tok_len == '0) cur_state = start_state;
        if (walk_edge(it.symbol) != WalkOk) begin
          if (tok_len == '0) begin
            add_result(dts_pkg::KindDrop, '0, '0, 1'b0);
          end else begin
            // close the token, then retry the ending byte from the start state
            add_result(dts_pkg::KindToken, tok_tag, tok_len, tok_seen_acc);
            restart_token();
            if (walk_edge(it.symbol) != WalkOk) add_result(dts_pkg::KindDrop, '0, '0, 1'b0);
          end
        end
        if (it.end_of_input) begin
          add_result(dts_pkg::KindToken, tok_tag, tok_len, tok_seen_acc);
          restart_token();
        end
        if (n_burst > 0) burst[n_burst-1].last = 1'b1;
        for (i = 0; i < n_burst; i++) token_results_q.push_back(burst[i]);
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_state = '0;
      restart_token();
      token_results_q.delete();
    end else begin
      if (cfg_we_i) begin
        start_state = cfg_wdata_i;
        if (tok_len == '0) cur_state = start_state;
      end
      if (in_valid_i && !in_stall_i) lex_item(in_item_i);
      if (out_valid_i && !out_stall_i) begin
        if (token_results_q.size() == 0) begin
          if (fails < 10) begin
            $display("unexpected result: kind=%0d tag=%h len=%0d matched=%0d last=%0d",
                     out_item_i.kind, out_item_i.token_tag, out_item_i.token_length,
                     out_item_i.matched, out_item_i.last);
          end
          fails++;
        end else begin
          want = token_results_q.pop_front();
          if (want.kind !== out_item_i.kind || want.token_tag !== out_item_i.token_tag ||
              want.token_length !== out_item_i.token_length ||
              want.matched !== out_item_i.matched || want.last !== out_item_i.last) begin
            if (fails < 10) begin
              $display("result mismatch at %0t: expected kind=%0d tag=%h len=%0d matched=%0d last=%0d",
                       $realtime, want.kind, want.token_tag, want.token_length, want.matched,
                       want.last);
              $display("                      got kind=%0d tag=%h len=%0d matched=%0d last=%0d",
                       out_item_i.kind, out_item_i.token_tag, out_item_i.token_length,
                       out_item_i.matched, out_item_i.last);
            end
            fails++;
          end
        end
      end
    end
  end

endmodule

>>> verif/dfa_token_scanner_top_test.sv
`timescale 1ns / 1ps
// testbench top: stimulus, idling and verdict for the dfa token scanner
module dfa_token_scanner_top_test;

  localparam logic [dts_pkg::FuncBits-1:0] FuncUnused = 2'd3;

  // the active states and symbols; every pair of them is always written in the table
  localparam logic [dts_pkg::StateBits-1:0] St0 = 8'd0;
  localparam logic [dts_pkg::StateBits-1:0] St1 = 8'd1;
  localparam logic [dts_pkg::StateBits-1:0] St2 = 8'd2;
  localparam logic [dts_pkg::StateBits-1:0] StTop = 8'd255;
  localparam logic [dts_pkg::SymBits-1:0] SymLo = 8'h00;
  localparam logic [dts_pkg::SymBits-1:0] SymHi = 8'hFF;
  localparam logic [dts_pkg::SymBits-1:0] SymMixA = 8'h5A;
  localparam logic [dts_pkg::SymBits-1:0] SymMixB = 8'hA5;
  localparam logic [dts_pkg::NextBits-1:0] NoEdge = 9'h100;

  logic                          clk;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  dts_pkg::in_item_t             in_item = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  dts_pkg::out_item_t            out_item;
  logic                          cfg_we = 1'b0;
  logic [dts_pkg::StateBits-1:0] cfg_wdata = '0;
  int                            pending;
  int                            fail_count;
  logic                          calm = 1'b0;
  int                            stall_left = 0;

  dfa_token_scanner_top i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  dfa_token_scanner_checker i_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_item_i   (in_item),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_item_i  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .pending_o   (pending),
    .fail_count_o(fail_count)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // receiver pacing: mostly no stall, else short stalls, now and then a long one
  always @(posedge clk) begin : out_pacer
    int roll;
    if (calm) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else begin
      roll = $urandom_range(99);
      if (roll < 60) begin
        out_stall <= 1'b0;
        stall_left = $urandom_range(6, 0);
      end else if (roll < 92) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(3, 0);
      end else begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(40, 10);
      end
    end
  end

  function automatic dts_pkg::in_item_t rand_item();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    return raw[$bits(dts_pkg::in_item_t)-1:0];
  endfunction

  function automatic logic [dts_pkg::SymBits-1:0] pick_sym();
    case ($urandom_range(3))
      0: return SymLo;
      1: return SymHi;
      2: return SymMixA;
      default: return SymMixB;
    endcase
  endfunction

  function automatic logic [dts_pkg::StateBits-1:0] pick_state();
    case ($urandom_range(3))
      0: return St0;
      1: return St1;
      2: return St2;
      default: return StTop;
    endcase
  endfunction

  function automatic logic [dts_pkg::NextBits-1:0] pick_target();
    if ($urandom_range(3) == 0) return dts_pkg::NextBits'($urandom_range(511, 256));
    return {1'b0, pick_state()};
  endfunction

  function automatic int pick_gap();
    int roll;
    if (calm) return 0;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  task automatic send_item(input dts_pkg::in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_item <= it;
    in_valid <= 1'b1;
    do begin
      @(posedge clk);
    end while (in_stall);
  endtask

  task automatic scan(input logic [dts_pkg::SymBits-1:0] sym, input logic eoi);
    dts_pkg::in_item_t it;
    it = rand_item();
    it.func = dts_pkg::FuncScan;
    it.symbol = sym;
    it.end_of_input = eoi;
    send_item(it);
  endtask

  task automatic put_edge(input logic [dts_pkg::StateBits-1:0] from,
                          input logic [dts_pkg::SymBits-1:0] sym,
                          input logic [dts_pkg::NextBits-1:0] to);
    dts_pkg::in_item_t it;
    it = rand_item();
    it.func = dts_pkg::FuncWrTrans;
    it.state_sel = from;
    it.symbol = sym;
    it.next_state = to;
    send_item(it);
  endtask

  task automatic put_attr(input logic [dts_pkg::StateBits-1:0] st, input logic acc,
                          input logic [dts_pkg::TagWidth-1:0] tag);
    dts_pkg::in_item_t it;
    it = rand_item();
    it.func = dts_pkg::FuncWrAttr;
    it.state_sel = st;
    it.accept_in = acc;
    it.tag_in = tag;
    send_item(it);
  endtask

  // drain: nothing expected, then let trailing table writes settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic set_initial(input logic [dts_pkg::StateBits-1:0] st);
    wait_idle();
    cfg_wdata <= st;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly scans over the active symbols; rewrites keep the active table complete
  task automatic send_random(output bit counts);
    dts_pkg::in_item_t it;
    int roll;
    it = rand_item();
    counts = 1'b1;
    roll = $urandom_range(99);
    if (roll < 70) begin
      it.func = dts_pkg::FuncScan;
      it.symbol = pick_sym();
      it.end_of_input = ($urandom_range(7) == 0);
    end else if (roll < 80) begin
      it.func = dts_pkg::FuncWrTrans;
      it.state_sel = pick_state();
      it.symbol = pick_sym();
      it.next_state = pick_target();
    end else if (roll < 86) begin
      it.func = dts_pkg::FuncWrAttr;
      it.state_sel = pick_state();
    end else if (roll < 95) begin
      // writes to rows that are never scanned
      it.func = $urandom_range(1) ? dts_pkg::FuncWrTrans : dts_pkg::FuncWrAttr;
      it.state_sel = dts_pkg::StateBits'($urandom_range(254, 3));
    end else begin
      it.func = FuncUnused;
      counts = 1'b0;
    end
    send_item(it);
  endtask

  initial begin
    dts_pkg::in_item_t it;
    int ph;
    int counted;
    bit counts;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    put_attr(St0, 1'b0, 16'h0000);
    put_attr(St1, 1'b1, 16'hFFFF);
    put_attr(St2, 1'b0, 16'h1234);
    put_attr(StTop, 1'b1, 16'h0001);
    put_edge(St0, SymLo, St1);
    put_edge(St0, SymHi, NoEdge);
    put_edge(St0, SymMixA, St2);
    put_edge(St0, SymMixB, 9'h1FF);
    put_edge(St1, SymLo, St1);
    put_edge(St1, SymHi, St2);
    put_edge(St1, SymMixA, StTop);
    put_edge(St1, SymMixB, 9'd300);
    put_edge(St2, SymLo, St2);
    put_edge(St2, SymHi, St1);
    put_edge(St2, SymMixA, NoEdge);
    put_edge(St2, SymMixB, St0);
    put_edge(StTop, SymLo, StTop);
    put_edge(StTop, SymHi, St0);
    put_edge(StTop, SymMixA, St1);
    put_edge(StTop, SymMixB, NoEdge);

    scan(SymHi, 1'b0);    // no edge from the start state: dropped
    scan(SymLo, 1'b0);
    scan(SymLo, 1'b0);
    scan(SymHi, 1'b0);    // leaves accepting: token, then the retry is dropped
    scan(SymMixA, 1'b0);
    scan(SymMixB, 1'b0);
    scan(SymMixB, 1'b1);  // token, drop and an empty final token
    scan(SymHi, 1'b1);
    it = rand_item();
    it.func = FuncUnused;
    it.end_of_input = 1'b1;
    send_item(it);
    it = rand_item();
    it.func = dts_pkg::FuncWrTrans;
    it.state_sel = St0;
    it.symbol = SymLo;
    it.next_state = {1'b0, St1};
    it.end_of_input = 1'b1;
    send_item(it);
    scan(SymLo, 1'b1);
    scan(SymMixA, 1'b0);
    scan(SymMixA, 1'b0);  // unmatched token, retry succeeds
    scan(SymHi, 1'b0);
    scan(SymMixA, 1'b0);
    scan(SymLo, 1'b0);
    scan(SymHi, 1'b0);

    set_initial(StTop);
    scan(SymMixB, 1'b0);
    scan(SymMixA, 1'b0);
    scan(SymMixB, 1'b0);
    scan(SymLo, 1'b1);
    scan(SymLo, 1'b0);
    // new start state only applies once the open token ends
    set_initial(St0);
    scan(SymHi, 1'b0);

    for (ph = 0; ph < 3; ph++) begin
      set_initial(pick_state());
      calm = (ph == 1) || ($urandom_range(4) == 0);
      counted = 0;
      while (counted < 20) begin
        send_random(counts);
        if (counts) counted++;
      end
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
